/* hw/rtl/bts_pkg.sv */
`default_nettype none
package bts_pkg;

  localparam logic [6:0] CH_MASK  = 7'h7f;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_LF    = 7'h0a;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_PCT   = 7'h25;
  localparam logic [6:0] CH_DEL   = 7'h7f;

  // outcome of one nonzero byte against the history
  typedef struct packed {
    logic       keep;   // character is accepted
    logic       held;   // space or dot; goes to the hold buffer if accepted
    logic [6:0] chr;    // mapped character
  } bts_class_t;

endpackage
`default_nettype wire

/* hw/rtl/bts_ram.sv */
`default_nettype none
module bts_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/bts_classify.sv */
`default_nettype none
module bts_classify
  import bts_pkg::*;
(
  input  wire logic [7:0] raw,
  input  wire logic [6:0] prev_one,
  input  wire logic [6:0] prev_two,
  input  wire logic       started,
  output bts_class_t      cls
);

  logic [6:0] c;
  logic       is_blank;
  logic       is_dot;
  logic       pct_run;

  assign c        = raw[6:0] & CH_MASK;
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
  assign is_dot   = (c == CH_DOT) || (c < CH_SPACE) || (c == CH_DEL);
  assign pct_run  = (c == CH_PCT) && (prev_one == CH_PCT) && (prev_two == CH_PCT);

  always_comb begin
    cls.keep = 1'b1;
    cls.held = 1'b0;
    cls.chr  = c;
    if (is_blank) begin
      cls.chr  = CH_SPACE;
      cls.held = 1'b1;
      if (!started || (prev_one == CH_SPACE && prev_two == CH_SPACE)) begin
        cls.keep = 1'b0;
      end
    end else if (is_dot) begin
      cls.chr  = CH_DOT;
      cls.held = 1'b1;
      if (!started || (prev_one == CH_DOT && prev_two == CH_DOT)) begin
        cls.keep = 1'b0;
      end
    end else if (pct_run) begin
      cls.keep = 1'b0;
    end
    // zero bytes never reach the history, keep stays harmless here
    if (raw == 8'h00) begin
      cls.keep = 1'b0;
      cls.held = 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/broadcast_text_sanitizer_top.sv */
`default_nettype none
// Message text filter, one byte per beat in, one character or terminator per
// beat out. Trailing spaces and dots sit in a circular hold buffer kept in a
// single-port-read RAM of HOLD_DEPTH entries; releasing a held run reads each
// held character from the RAM, then loads it into the output register, and
// after the run emits the real character that frees it. A space or dot
// arriving on a full buffer reads the oldest, then emits it and overwrites
// its slot together. A terminator that follows an emitted character goes out
// from a separate terminator state. New bytes are taken only when the
// sequencer is idle and the output register is free or being emptied.
module broadcast_text_sanitizer_top
  import bts_pkg::*;
#(
  parameter int HOLD_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [6:0] out_char,
  output logic            char_valid,
  output logic            end_of_message
);

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN_RD,
    S_DRAIN_WR,
    S_CHAR,
    S_POP_RD,
    S_POP_WR,
    S_TERM
  } state_t;

  state_t      state;
  logic [6:0]  prev_one;
  logic [6:0]  prev_two;
  logic        started;
  logic [AW-1:0] head;
  logic [CW-1:0] hold_count;
  logic [6:0]  pend_char;
  logic        pend_last;

  bts_class_t  cls;
  logic        out_free;
  logic        accept;
  logic        is_zero;
  logic        full;
  logic [AW-1:0] head_next;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [6:0]    ram_wdata;
  logic          ram_re;
  logic [6:0]    ram_rdata;

  bts_classify u_classify (
    .raw      (in_byte),
    .prev_one (prev_one),
    .prev_two (prev_two),
    .started  (started),
    .cls      (cls)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;
  assign is_zero  = (in_byte == 8'h00);
  assign full     = (hold_count == CW'(HOLD_DEPTH));

  assign head_next = (head == AW'(HOLD_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum  = (AW+1)'(head) + (AW+1)'(hold_count);
  assign tail      = (tail_sum >= (AW+1)'(HOLD_DEPTH)) ?
                     AW'(tail_sum - (AW+1)'(HOLD_DEPTH)) : AW'(tail_sum);

  // a held character is written at the tail; the oldest slot is reused on a full-buffer push, after its read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = cls.chr;
    if (state == S_POP_WR) begin
      ram_we    = out_free;
      ram_waddr = head;
      ram_wdata = pend_char;
    end else if (accept && cls.keep && cls.held && !full && !in_last) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = (state == S_DRAIN_RD) || (state == S_POP_RD);

  bts_ram #(
    .WIDTH (7),
    .DEPTH (HOLD_DEPTH)
  ) u_hold (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_one   <= '0;
      prev_two   <= '0;
      started    <= 1'b0;
      head       <= '0;
      hold_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cls.keep) begin
              prev_two <= prev_one;
              prev_one <= cls.chr;
              started  <= 1'b1;
            end
            if (is_zero || in_last) begin
              prev_one <= '0;
              prev_two <= '0;
              started  <= 1'b0;
            end
            pend_char <= cls.chr;
            pend_last <= in_last;
            if (is_zero) begin
              out_valid      <= 1'b1;
              out_char       <= '0;
              char_valid     <= 1'b0;
              end_of_message <= 1'b1;
              head           <= '0;
              hold_count     <= '0;
            end else if (cls.keep && !cls.held && hold_count != '0) begin
              state <= S_DRAIN_RD;
            end else if (cls.keep && !cls.held) begin
              out_valid      <= 1'b1;
              out_char       <= cls.chr;
              char_valid     <= 1'b1;
              end_of_message <= 1'b0;
              if (in_last) begin
                state <= S_TERM;
              end
            end else if (cls.keep && full) begin
              state <= S_POP_RD;
            end else if (in_last) begin
              out_valid      <= 1'b1;
              out_char       <= '0;
              char_valid     <= 1'b0;
              end_of_message <= 1'b1;
              head           <= '0;
              hold_count     <= '0;
            end else if (cls.keep) begin
              hold_count <= hold_count + 1'b1;
            end
          end
        end
        S_DRAIN_RD: begin
          state <= S_DRAIN_WR;
        end
        S_DRAIN_WR: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_char       <= ram_rdata;
            char_valid     <= 1'b1;
            end_of_message <= 1'b0;
            head           <= head_next;
            hold_count     <= hold_count - 1'b1;
            state          <= (hold_count == CW'(1)) ? S_CHAR : S_DRAIN_RD;
          end
        end
        S_CHAR: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_char       <= pend_char;
            char_valid     <= 1'b1;
            end_of_message <= 1'b0;
            head           <= '0;
            state          <= pend_last ? S_TERM : S_IDLE;
          end
        end
        S_POP_RD: begin
          state <= S_POP_WR;
        end
        S_POP_WR: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_char       <= ram_rdata;
            char_valid     <= 1'b1;
            end_of_message <= 1'b0;
            head           <= head_next;
            state          <= pend_last ? S_TERM : S_IDLE;
          end
        end
        S_TERM: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_char       <= '0;
            char_valid     <= 1'b0;
            end_of_message <= 1'b1;
            head           <= '0;
            hold_count     <= '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hold_count <= CW'(HOLD_DEPTH))
    else $error("hold count beyond buffer depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(HOLD_DEPTH - 1))
    else $error("hold head pointer out of range");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN_RD || state == S_DRAIN_WR) |-> hold_count != '0)
    else $error("draining an empty hold buffer");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_message && state == S_IDLE) |-> hold_count == '0)
    else $error("terminator sent with characters still held");

  a_pop_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_RD) |-> full)
    else $error("oldest-character pop on a buffer that is not full");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  localparam int HOLD_DEPTH  = 16;
  localparam int ITEM_TARGET = 430;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF    = 400;
  localparam int IDLE_PCT    = 11;

  // byte classes for the stimulus
  localparam int CAT_TEXT    = 0;
  localparam int CAT_BLANK   = 1;
  localparam int CAT_DOTLIKE = 2;
  localparam int CAT_PCT     = 3;
  localparam int CAT_ANY     = 4;

  typedef struct packed {
    logic [6:0] chr;
    logic       cv;
    logic       eom;
  } text_beat_t;

  class char_scoreboard;
    logic [6:0] last_char;
    logic [6:0] char_before;
    bit         started;
    logic [6:0] held_blanks[$];
    text_beat_t due_chars[$];
    int         errors;

    function new();
      clear_message();
      errors = 0;
    endfunction

    function void clear_message();
      last_char   = '0;
      char_before = '0;
      started     = 1'b0;
      held_blanks.delete();
    endfunction

    function void push_due(logic [6:0] chr, logic cv, logic eom);
      text_beat_t t;
      t.chr = chr;
      t.cv  = cv;
      t.eom = eom;
      due_chars.push_back(t);
    endfunction

    // filter one accepted byte and queue the characters it releases
    function void take_byte(logic [7:0] raw, logic last);
      logic [6:0] c;
      bit         drop;
      c    = raw[6:0];
      drop = 1'b0;
      if (raw != 8'h00) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
          if (!started || (last_char == CH_SPACE && char_before == CH_SPACE)) drop = 1'b1;
          else c = CH_SPACE;
        end else if (c == CH_DOT || c < CH_SPACE || c == CH_DEL) begin
          if (!started || (last_char == CH_DOT && char_before == CH_DOT)) drop = 1'b1;
          else c = CH_DOT;
        end else if (c == CH_PCT && last_char == CH_PCT && char_before == CH_PCT) begin
          drop = 1'b1;
        end
        if (!drop) begin
          char_before = last_char;
          last_char   = c;
          started     = 1'b1;
          if (c == CH_SPACE || c == CH_DOT) begin
            if (held_blanks.size() >= HOLD_DEPTH) push_due(held_blanks.pop_front(), 1'b1, 1'b0);
            held_blanks.push_back(c);
          end else begin
            foreach (held_blanks[i]) push_due(held_blanks[i], 1'b1, 1'b0);
            held_blanks.delete();
            push_due(c, 1'b1, 1'b0);
          end
        end
      end
      if (raw == 8'h00 || last) begin
        push_due('0, 1'b0, 1'b1);
        clear_message();
      end
    endfunction

    function void match_char(logic [6:0] chr, logic cv, logic eom);
      text_beat_t exp_beat;
      if (due_chars.size() == 0) begin
        $display("%0t: unexpected beat chr %h char_valid %b eom %b", $time, chr, cv, eom);
        errors++;
        return;
      end
      exp_beat = due_chars.pop_front();
      if (chr !== exp_beat.chr) begin
        $display("%0t: out_char expected %h actual %h", $time, exp_beat.chr, chr);
        errors++;
      end
      if (cv !== exp_beat.cv) begin
        $display("%0t: char_valid expected %b actual %b", $time, exp_beat.cv, cv);
        errors++;
      end
      if (eom !== exp_beat.eom) begin
        $display("%0t: end_of_message expected %b actual %b", $time, exp_beat.eom, eom);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_char;
  logic       char_valid;
  logic       end_of_message;

  char_scoreboard sb;
  bit idle_on;
  bit hold_req;
  bit hold_sent;
  int sent_items;

  always #4 clk = ~clk;

  broadcast_text_sanitizer_top #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .end_of_message(end_of_message)
  );

  // input beat is noted before the output is checked in the same edge
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (in_valid && in_stall === 1'b0) sb.take_byte(in_byte, in_last);
      if (out_valid === 1'b1 && !out_stall) sb.match_char(out_char, char_valid, end_of_message);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  // receiver side, with one long hold-off on request
  initial begin : sink
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(negedge clk);
      end
      out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input logic [7:0] b, input logic l);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_byte  <= b;
    in_last  <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte(int cat);
    logic [7:0] b;
    case (cat)
      CAT_TEXT: b = 8'($urandom_range(8'h21, 8'h7e));
      CAT_BLANK: begin
        case ($urandom_range(0, 2))
          0:       b = {1'b0, CH_SPACE};
          1:       b = {1'b0, CH_TAB};
          default: b = {1'b0, CH_LF};
        endcase
      end
      CAT_DOTLIKE: begin
        case ($urandom_range(0, 2))
          0:       b = {1'b0, CH_DOT};
          1:       b = {1'b0, CH_DEL};
          default: b = 8'($urandom_range(1, 31));
        endcase
      end
      CAT_PCT: b = {1'b0, CH_PCT};
      default: b = 8'($urandom_range(1, 255));
    endcase
    if (cat != CAT_ANY && $urandom_range(0, 3) == 0) b[7] = 1'b1;
    return b;
  endfunction

  function automatic logic [7:0] mixed_byte();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return pick_byte(CAT_TEXT);
    if (k < 58) return pick_byte(CAT_BLANK);
    if (k < 73) return pick_byte(CAT_DOTLIKE);
    if (k < 85) return pick_byte(CAT_PCT);
    return pick_byte(CAT_ANY);
  endfunction

  task automatic send_message();
    int len;
    int run_len;
    bit end_on_flag;
    len         = $urandom_range(0, 12);
    end_on_flag = $urandom_range(0, 99) < 75;
    // a long blank and dot run that may overflow the hold buffer
    if ($urandom_range(0, 99) < 15) begin
      run_len = $urandom_range(HOLD_DEPTH - 2, HOLD_DEPTH + 6);
      send_beat(pick_byte(CAT_TEXT), 1'b0);
      for (int i = 0; i < run_len; i++)
        send_beat(((i % 4) < 2) ? pick_byte(CAT_BLANK) : pick_byte(CAT_DOTLIKE), 1'b0);
    end
    for (int i = 0; i < len; i++) send_beat(mixed_byte(), end_on_flag && i == len - 1);
    if (!end_on_flag || len == 0) send_beat(8'h00, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    in_last    = 1'b0;
    out_stall  = 1'b0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    hold_sent  = 1'b0;
    sent_items = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty messages, with and without the last flag
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b1);
    // leading blanks and dots dropped, high bit masked
    send_beat(8'h80, 1'b0);
    send_beat(8'h0a, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h2e, 1'b0);
    send_beat(8'h41, 1'b1);
    // third and later percents in a row dropped
    send_beat(8'h42, 1'b0);
    send_beat(8'h25, 1'b0);
    send_beat(8'h25, 1'b0);
    send_beat(8'h25, 1'b0);
    send_beat(8'ha5, 1'b1);
    // held run released by a real char, then a held run thrown away
    send_beat(8'h43, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h09, 1'b0);
    send_beat(8'h0a, 1'b0);
    send_beat(8'h2e, 1'b0);
    send_beat(8'hae, 1'b0);
    send_beat(8'h7f, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'hc4, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b1);
    // trailing blank dropped at the last flag
    send_beat(8'h7e, 1'b0);
    send_beat(8'h20, 1'b1);

    while (sent_items < ITEM_TARGET) begin
      idle_on = !(sent_items >= 40 && sent_items < 150);
      if (sent_items >= 260 && !hold_sent) begin
        hold_req  = 1'b1;
        hold_sent = 1'b1;
      end
      send_message();
    end
    in_valid <= 1'b0;

    while (sb.due_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.due_chars.size() == 0) begin
      $display("tb_top passed");
    end else begin
      if (sb.due_chars.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, sb.due_chars.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
